@@ src/sorted_list_merge_macros.svh @@
// Assertion macros shared by the checker of the list merge block.
`ifndef SORTED_LIST_MERGE_MACROS_SVH
`define SORTED_LIST_MERGE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/slm_pkg.sv @@
// Types and constants shared by the sorted list merge modules.
`timescale 1ns / 1ps

package slm_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD_DAILY  = 2'd0,
    REQ_LOAD_MASTER = 2'd1,
    REQ_RUN         = 2'd2
  } req_code_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [19:0] subject_code;
    logic [26:0] file_number;
    logic [15:0] name_ref;
  } req_item_t;

  typedef struct packed {
    logic [19:0] subject_code_out;
    logic [26:0] file_number_out;
    logic [15:0] name_ref_out;
    logic        from_master;
    logic        last_record;
  } rsp_item_t;

  // One stored record, 63 bits.
  typedef struct packed {
    logic [15:0] name_ref;
    logic [26:0] file_number;
    logic [19:0] subject_code;
  } record_t;

  localparam int REC_W = $bits(record_t);

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic load_daily;
    logic load_master;
    logic emit;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_pick;
    logic lists_empty;
  } status_t;

endpackage

@@ src/slm_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module slm_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/slm_datapath.sv @@
// Datapath of the list merge: list stores, counts, read pointers and output register.
`timescale 1ns / 1ps

module slm_datapath #(
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  slm_pkg::req_item_t req_item,
  input  slm_pkg::cmd_t      cmd,
  output slm_pkg::status_t   sts,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output slm_pkg::rsp_item_t rsp_item
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  logic [CW-1:0] daily_count, daily_count_next;
  logic [CW-1:0] master_count, master_count_next;
  logic [CW-1:0] daily_ptr, daily_ptr_next;
  logic [CW-1:0] master_ptr, master_ptr_next;

  slm_pkg::record_t wr_rec;
  slm_pkg::record_t daily_head, master_head, pick;
  logic daily_we, master_we;
  logic daily_avail, master_avail, take_daily, last_pick;

  assign wr_rec.subject_code = req_item.subject_code;
  assign wr_rec.file_number  = req_item.file_number;
  assign wr_rec.name_ref     = req_item.name_ref;

  assign daily_we  = cmd.load_daily && (daily_count < CW'(LIST_DEPTH));
  assign master_we = cmd.load_master && (master_count < CW'(LIST_DEPTH));

  // The read address follows the pointer's next value, so the registered read
  // data holds the current head of each list by the time a merge run reads it.
  slm_ram #(.WIDTH(slm_pkg::REC_W), .DEPTH(LIST_DEPTH)) u_daily_ram (
    .clk   (clk),
    .we    (daily_we),
    .waddr (daily_count[AW-1:0]),
    .wdata (wr_rec),
    .raddr (daily_ptr_next[AW-1:0]),
    .rdata (daily_head)
  );

  slm_ram #(.WIDTH(slm_pkg::REC_W), .DEPTH(LIST_DEPTH)) u_master_ram (
    .clk   (clk),
    .we    (master_we),
    .waddr (master_count[AW-1:0]),
    .wdata (wr_rec),
    .raddr (master_ptr_next[AW-1:0]),
    .rdata (master_head)
  );

  assign daily_avail  = daily_ptr < daily_count;
  assign master_avail = master_ptr < master_count;

  // On equal keys the master record goes first.
  assign take_daily = daily_avail &&
                      (!master_avail || (daily_head.subject_code < master_head.subject_code));
  assign pick = take_daily ? daily_head : master_head;

  assign last_pick = ({1'b0, daily_ptr} + {1'b0, master_ptr} + (CW+1)'(1)) ==
                     ({1'b0, daily_count} + {1'b0, master_count});

  assign sts.out_free    = !rsp_valid || rsp_ready;
  assign sts.last_pick   = last_pick;
  assign sts.lists_empty = (daily_count == '0) && (master_count == '0);

  always_comb begin
    daily_count_next  = daily_count;
    master_count_next = master_count;
    daily_ptr_next    = daily_ptr;
    master_ptr_next   = master_ptr;
    if (daily_we) begin
      daily_count_next = daily_count + CW'(1);
    end
    if (master_we) begin
      master_count_next = master_count + CW'(1);
    end
    if (cmd.emit) begin
      if (take_daily) begin
        daily_ptr_next = daily_ptr + CW'(1);
      end else begin
        master_ptr_next = master_ptr + CW'(1);
      end
    end
    if (cmd.clear) begin
      daily_count_next  = '0;
      master_count_next = '0;
      daily_ptr_next    = '0;
      master_ptr_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      daily_count  <= '0;
      master_count <= '0;
      daily_ptr    <= '0;
      master_ptr   <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      daily_count  <= daily_count_next;
      master_count <= master_count_next;
      daily_ptr    <= daily_ptr_next;
      master_ptr   <= master_ptr_next;
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_item.subject_code_out <= pick.subject_code;
      rsp_item.file_number_out  <= pick.file_number;
      rsp_item.name_ref_out     <= pick.name_ref;
      rsp_item.from_master      <= !take_daily;
      rsp_item.last_record      <= last_pick;
    end
  end

endmodule

@@ src/slm_controller.sv @@
// Controller of the list merge: decodes requests and steps the merge run.
`timescale 1ns / 1ps

module slm_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [1:0]        req_type,
  input  slm_pkg::status_t   sts,
  output slm_pkg::cmd_t      cmd
);

  slm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          unique case (req_type)
            slm_pkg::REQ_LOAD_DAILY:  cmd.load_daily  = 1'b1;
            slm_pkg::REQ_LOAD_MASTER: cmd.load_master = 1'b1;
            slm_pkg::REQ_RUN: begin
              // A run over two empty lists gives nothing and leaves no trace.
              if (!sts.lists_empty) begin
                state_next = slm_pkg::ST_MERGE;
              end
            end
            default: ;
          endcase
        end
      end
      slm_pkg::ST_MERGE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_pick) begin
            cmd.clear  = 1'b1;
            state_next = slm_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = slm_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ src/sorted_list_merge.sv @@
// Load requests may follow back to back; a record beyond LIST_DEPTH in
// either list is dropped. A run request emits every held record, merged in
// ascending subject code with the master record first on equal codes, at one
// item per cycle while the result side keeps up, and the request side stays
// blocked until the last record of the run is picked; the rate is set by the
// single head read of each list store per cycle.
// A run over two empty lists gives no item and the block is ready again in
// the next cycle. Both lists are empty after reset and after every run, and
// requests may be sent while the final item of a run still waits to be taken.
`timescale 1ns / 1ps

module sorted_list_merge #(
  parameter int LIST_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  slm_pkg::req_item_t req_item,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output slm_pkg::rsp_item_t rsp_item
);

  slm_pkg::cmd_t    cmd;
  slm_pkg::status_t sts;

  slm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_type  (req_item.req_type),
    .sts       (sts),
    .cmd       (cmd)
  );

  slm_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_item  (rsp_item)
  );

endmodule

@@ src/slm_checker.sv @@
// Port level checks of the sorted list merge, bound to the top level.
`timescale 1ns / 1ps
`include "sorted_list_merge_macros.svh"

module slm_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input slm_pkg::req_item_t req_item,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input slm_pkg::rsp_item_t rsp_item
);

  // A stalled result item holds still.
  `SLM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "result item changed while stalled")

  // While a run is unfinished, no request is taken.
  `SLM_ASSERT_NOW(a_run_blocks, rsp_valid && !rsp_item.last_record, !req_ready, "request side open during a run")

  // A new result item only appears after requests were held off, as they are in a run.
  `SLM_ASSERT_NOW(a_rsp_from_run, $rose(rsp_valid), !$past(req_ready), "result item without a run")

endmodule

bind sorted_list_merge slm_checker u_slm_checker (.*);
